### rtl/mpfd_pkg.sv
// Shared types and constants for the Manchester parity frame decoder.
package mpfd_pkg;

  localparam int unsigned FrameBytes = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned FrameW     = 64;
  localparam int unsigned PosBits    = 56;
  localparam int unsigned IdW        = 27;
  localparam int unsigned FlagW      = 10;
  localparam int unsigned OffsetW    = 7;
  localparam int unsigned RssiW      = 8;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 80;

  localparam logic [4:0] MarkerAll = 5'h1f;
  localparam logic [1:0] PairOne   = 2'b01;
  localparam logic [1:0] PairZero  = 2'b10;

  typedef enum logic [1:0] {
    STATUS_DECODED   = 2'd0,
    STATUS_SYMBOL    = 2'd1,
    STATUS_PARITY    = 2'd2,
    STATUS_IGNORED   = 2'd3
  } status_e;

endpackage

### rtl/manchester_parity_frame_decoder_top.sv
// Manchester frame decoder with 2-D parity check: top level.
//
// Slave stream: one raw radio byte per request. tlast marks the final byte
// of a frame; rssi and receive_enabled are only looked at on that byte.
// Master stream: one result per frame, presented the cycle after the final
// byte is accepted. Bytes are taken at one per cycle unless held off; the
// decode of a whole frame is done in the single cycle that accepts its final
// byte, from the collected 64-bit shift register.
// Config channel: writes rssi_offset; always ready. The user must use it
// only while idle; the block does not enforce this. The result sits in an
// output register. While it waits, s_axis_tready stays high for bytes
// that do not end a frame; a final byte is held off only when the output
// register is full and the receiver is stalling. Reset clears the frame
// collection, the stored id/value/flags/version and rssi_offset, and empties
// the output register. Result: status 0 decoded, 1 symbol error, 2 parity
// error, 3 ignored (wrong length or receive disabled); stored fields are
// shown as they stand after the frame.
module manchester_parity_frame_decoder_top
  import mpfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] rx_byte, [15:8] rssi, [16] receive_enabled, [23:17] zero
  input  logic [InDataW-1:0]    s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [3:2] version, [30:4] module_id, [57:31] module_value,
  // [67:58] control_flags, [68] notify, [76:69] rssi_out, [79:77] zero
  output logic [OutDataW-1:0]   m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [OffsetW-1:0]    cfg_data_i
);

  logic                 in_acc;
  logic                 frame_end;
  logic [7:0]           rx_byte;
  logic [RssiW-1:0]     rssi_in;
  logic                 rx_en;

  logic [FrameW-1:0]    frame_q, frame_d, frame_sh;
  logic [CountW-1:0]    cnt_q, cnt_d, cnt_inc;
  logic                 sym_q, sym_d, sym_now, sym_any;
  logic [3:0]           nib;
  logic [1:0]           pair;

  logic [IdW-1:0]       id_q, id_d;
  logic [IdW-1:0]       value_q, value_d;
  logic [FlagW-1:0]     flags_q, flags_d;
  logic [1:0]           ver_q, ver_d;
  logic [OffsetW-1:0]   offset_q;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic                 notify_q, notify_d;
  logic [RssiW-1:0]     rssi_out_q, rssi_out_d;

  logic [7:0]           dbyte [8];
  logic [7:0]           col;
  logic                 row_bad;
  logic                 parity_good;
  logic [PosBits-1:0]   pv;
  logic [RssiW:0]       rsum;
  logic [FlagW-1:0]     flags_rev;

  assign rx_byte = s_axis_tdata[7:0];
  assign rssi_in = s_axis_tdata[15:8];
  assign rx_en   = s_axis_tdata[16];

  assign s_axis_tready = !out_valid_q || m_axis_tready || !s_axis_tlast;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign frame_end     = in_acc && s_axis_tlast;
  assign cfg_ready_o   = 1'b1;

  // Manchester decode of the incoming byte, most significant pair first
  always_comb begin
    nib     = '0;
    sym_now = 1'b0;
    pair    = '0;
    for (int j = 0; j < 4; j++) begin
      pair       = rx_byte[7-2*j -: 2];
      nib[3-j]   = (pair == PairOne);
      if (pair != PairOne && pair != PairZero) begin
        sym_now = 1'b1;
      end
    end
  end

  assign frame_sh = {frame_q[FrameW-5:0], nib};
  assign cnt_inc  = (cnt_q == {CountW{1'b1}}) ? cnt_q : cnt_q + CountW'(1);
  assign sym_any  = sym_q | sym_now;

  // Row and column parity, and position map: bit p sits in byte p/7,
  // bit 7-(p%7); pv holds position p at index 55-p so fields read MSB first
  always_comb begin
    col     = '0;
    row_bad = 1'b0;
    pv      = '0;
    for (int k = 0; k < 8; k++) begin
      dbyte[k] = frame_sh[FrameW-1-8*k -: 8];
      col      = col ^ dbyte[k];
      row_bad  = row_bad | (^dbyte[k]);
      for (int j = 0; j < 7; j++) begin
        pv[PosBits-1-(7*k+j)] = frame_sh[FrameW-1-8*k-j];
      end
    end
    parity_good = !row_bad && (col == 8'h00);
    for (int i = 0; i < FlagW; i++) begin
      flags_rev[i] = pv[21-i];
    end
  end

  // rssi plus offset, saturated
  assign rsum = {rssi_in[RssiW-1], rssi_in} + {{2{offset_q[OffsetW-1]}}, offset_q};

  always_comb begin
    frame_d     = frame_q;
    cnt_d       = cnt_q;
    sym_d       = sym_q;
    id_d        = id_q;
    value_d     = value_q;
    flags_d     = flags_q;
    ver_d       = ver_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    status_d    = status_q;
    notify_d    = notify_q;
    rssi_out_d  = rssi_out_q;

    if (in_acc && !s_axis_tlast) begin
      frame_d = frame_sh;
      cnt_d   = cnt_inc;
      sym_d   = sym_any;
    end

    if (frame_end) begin
      frame_d     = '0;
      cnt_d       = '0;
      sym_d       = 1'b0;
      out_valid_d = 1'b1;
      notify_d    = 1'b0;
      if (rsum[RssiW] != rsum[RssiW-1]) begin
        rssi_out_d = rsum[RssiW] ? {1'b1, {(RssiW-1){1'b0}}} : {1'b0, {(RssiW-1){1'b1}}};
      end else begin
        rssi_out_d = rsum[RssiW-1:0];
      end

      if (cnt_inc != CountW'(FrameBytes) || !rx_en) begin
        status_d = STATUS_IGNORED;
      end else if (sym_any) begin
        status_d = STATUS_SYMBOL;
      end else if (!parity_good) begin
        status_d = STATUS_PARITY;
      end else begin
        status_d = STATUS_DECODED;
        ver_d    = frame_sh[FrameW-1 -: 2];
        if (frame_sh[FrameW-1 -: 2] == 2'd0) begin
          if (pv[26:22] == MarkerAll) begin
            flags_d = flags_rev;
            if (id_q != pv[53:27]) begin
              id_d    = pv[53:27];
              value_d = '0;
            end else begin
              notify_d = 1'b1;
            end
          end else begin
            id_d    = pv[53:27];
            value_d = pv[26:0];
          end
        end else begin
          // short layout: two flags from the version byte, 20-bit id/value
          flags_d  = {{(FlagW-2){1'b0}}, frame_sh[FrameW-4], frame_sh[FrameW-3]};
          id_d     = {{(IdW-20){1'b0}}, pv[51:32]};
          value_d  = {{(IdW-20){1'b0}}, pv[31:12]};
          notify_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      cnt_q       <= '0;
      sym_q       <= 1'b0;
      id_q        <= '0;
      value_q     <= '0;
      flags_q     <= '0;
      ver_q       <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      cnt_q       <= cnt_d;
      sym_q       <= sym_d;
      id_q        <= id_d;
      value_q     <= value_d;
      flags_q     <= flags_d;
      ver_q       <= ver_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        offset_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    notify_q   <= notify_d;
    rssi_out_q <= rssi_out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, rssi_out_q, notify_q, flags_q, value_q, id_q, ver_q,
                          status_q};

endmodule

### rtl/mpfd_checker.sv
// Port-level assertions for the Manchester parity frame decoder, with bind.
module mpfd_checker
  import mpfd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_valid_i,
  input logic                 s_ready_i,
  input logic                 s_last_i,
  input logic                 m_valid_i,
  input logic                 m_ready_i,
  input logic [OutDataW-1:0]  m_data_i
);

  // a result only follows an accepted final byte
  a_result_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_i) |-> $past(s_valid_i && s_ready_i && s_last_i))
    else $error("result without a preceding final byte");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i))
    else $error("stalled result changed");

  // notification only on a decoded frame
  a_notify_decoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && m_data_i[68] |-> m_data_i[1:0] == STATUS_DECODED)
    else $error("notify set on a frame that did not decode");

  // a receiver that takes results never holds off the input
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_ready_i |-> s_ready_i)
    else $error("input stalled while output drains");

endmodule

bind manchester_parity_frame_decoder_top mpfd_checker u_mpfd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid),
  .s_ready_i (s_axis_tready),
  .s_last_i  (s_axis_tlast),
  .m_valid_i (m_axis_tvalid),
  .m_ready_i (m_axis_tready),
  .m_data_i  (m_axis_tdata)
);
